FILE: rtl/core/rsc_pkg.sv
// ----------------------------------------------------------------------------
// RPN stack calculator package
// Opcodes, status codes and the command and status records that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int DATA_W = 32;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_ADD     = 3'd1,
        OP_SUB     = 3'd2,
        OP_MUL     = 3'd3,
        OP_DIV     = 3'd4,
        OP_PRINT   = 3'd5,
        OP_CLEAR   = 3'd6,
        OP_UNKNOWN = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_PRINTED = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_FULL    = 3'd3,
        ST_NOTIMPL = 3'd4,
        ST_OVF     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ALU_NONE      = 3'd0,
        ALU_ADD       = 3'd1,
        ALU_SUB       = 3'd2,
        ALU_MUL       = 3'd3,
        ALU_MUL_FIN   = 3'd4,
        ALU_DIV_START = 3'd5
    } alu_cmd_t;

    typedef struct packed {
        logic     capture;
        logic     push;
        logic     clear;
        logic     rd_top;
        logic     rd_second;
        logic     ld_b;
        logic     ld_a;
        alu_cmd_t alu;
        logic     wr_res;
        logic     out_load;
        status_t  out_status;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_one;
        logic cnt_full;
        logic ovf;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: rtl/core/rpn_stack_calculator_top.sv
// ----------------------------------------------------------------------------
// RPN stack calculator
// Evaluates reverse-Polish commands over a stack of signed fixed-point
// values, one command per input transfer and one result transfer per command.
// A command is taken only while no other command is in progress, so the
// block handles one command at a time. Push, clear, print and unknown
// commands go from decode to the result; binary ones with two entries fetch
// their operands one after the other, as the stack is a single-port-write
// memory read one entry per cycle, then execute and write back; multiply
// adds a finishing step and divide waits on the divider, which yields one
// of its 33 quotient bits per cycle, skipping them if the operands force
// saturation. The result register lets the next command be taken while the
// previous result still waits for its transfer.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_top #(
    parameter int STACK_DEPTH = 64,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [2:0]                          opcode,
    input  logic signed [rsc_pkg::DATA_W-1:0]   operand_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rsc_pkg::DATA_W-1:0]   top_value,
    output logic [2:0]                          status
);

    rsc_pkg::dp_cmd_t  dp_cmd;
    rsc_pkg::dp_stat_t dp_stat;

    rsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .cmd      (dp_cmd),
        .stat     (dp_stat)
    );

    rsc_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .stat          (dp_stat),
        .operand_value (operand_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .top_value     (top_value),
        .status        (status)
    );

    a_busy_after_accept : assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("input accepted while a command was still in progress");

    a_value_only_on_print : assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (status != rsc_pkg::ST_PRINTED)) |-> (top_value == '0)
    ) else $error("nonzero top value on a result that is not a print");

    a_single_count_update : assert property (
        @(posedge clk) disable iff (!rst_n)
        $onehot0({dp_cmd.push, dp_cmd.clear, dp_cmd.wr_res})
    ) else $error("more than one stack count update in one cycle");

    a_load_when_free : assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !dp_cmd.out_load
    ) else $error("result register overwritten while its transfer is stalled");

endmodule

FILE: rtl/core/rsc_div.sv
// ----------------------------------------------------------------------------
// RPN stack calculator divider
// Signed fixed-point divide, one quotient bit per cycle, with saturation.
// ----------------------------------------------------------------------------
module rsc_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [rsc_pkg::DATA_W-1:0]   a,
    input  logic signed [rsc_pkg::DATA_W-1:0]   b,
    output logic                                done,
    output logic signed [rsc_pkg::DATA_W-1:0]   res,
    output logic                                ovf
);

    localparam int DW    = rsc_pkg::DATA_W;
    localparam int QW    = DW + 1;
    localparam int NW    = QW + DW;
    localparam int ITERW = $clog2(QW);

    localparam logic [QW-1:0] POS_LIM = {2'b00, {(DW-1){1'b1}}};
    localparam logic [QW-1:0] NEG_LIM = {2'b01, {(DW-1){1'b0}}};

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_FIN  = 3'b100
    } div_state_t;

    div_state_t         state_reg, state_next;
    logic [ITERW-1:0]   iter_reg, iter_next;
    logic               done_reg, done_next;
    logic [DW-1:0]      rem_reg, rem_next;
    logic [QW-1:0]      low_reg, low_next;
    logic [QW-1:0]      q_reg, q_next;
    logic [DW-1:0]      d_reg, d_next;
    logic               neg_reg, neg_next;
    logic signed [DW-1:0] res_reg, res_next;
    logic               ovf_reg, ovf_next;

    logic [QW-1:0] a_ext, b_ext, a_mag, b_mag;
    logic [NW-1:0] n_full;
    logic          pre_ovf, a_zero, start_neg;
    logic [QW-1:0] rem_sh, rem_sub, neg_q;
    logic          ge;

    always_comb
    begin
        a_ext     = {a[DW-1], a};
        b_ext     = {b[DW-1], b};
        a_mag     = a[DW-1] ? (QW'(0) - a_ext) : a_ext;
        b_mag     = b[DW-1] ? (QW'(0) - b_ext) : b_ext;
        n_full    = NW'(a_mag) << FRAC_BITS;
        pre_ovf   = {1'b0, n_full[NW-1:QW]} >= b_mag;
        a_zero    = (a == '0);
        start_neg = a[DW-1] ^ b[DW-1];

        rem_sh    = {rem_reg, low_reg[QW-1]};
        ge        = rem_sh >= {1'b0, d_reg};
        rem_sub   = rem_sh - {1'b0, d_reg};
        neg_q     = QW'(0) - q_reg;

        state_next = state_reg;
        iter_next  = iter_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        low_next   = low_reg;
        q_next     = q_reg;
        d_next     = d_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        ovf_next   = ovf_reg;

        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    neg_next = start_neg;
                    d_next   = b_mag[DW-1:0];
                    rem_next = n_full[NW-1:QW];
                    low_next = n_full[QW-1:0];
                    q_next   = '0;
                    iter_next = ITERW'(QW - 1);
                    if (pre_ovf)
                    begin
                        ovf_next  = 1'b1;
                        done_next = 1'b1;
                        if (a_zero)
                        begin
                            res_next = '0;
                        end
                        else
                        begin
                            res_next = start_neg ? rsc_pkg::DATA_MIN : rsc_pkg::DATA_MAX;
                        end
                    end
                    else
                    begin
                        state_next = D_RUN;
                    end
                end
            end
            D_RUN:
            begin
                rem_next  = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                q_next    = {q_reg[QW-2:0], ge};
                low_next  = {low_reg[QW-2:0], 1'b0};
                iter_next = iter_reg - ITERW'(1);
                if (iter_reg == '0)
                begin
                    state_next = D_FIN;
                end
            end
            D_FIN:
            begin
                if (neg_reg)
                begin
                    ovf_next = q_reg > NEG_LIM;
                    res_next = (q_reg > NEG_LIM) ? rsc_pkg::DATA_MIN : neg_q[DW-1:0];
                end
                else
                begin
                    ovf_next = q_reg > POS_LIM;
                    res_next = (q_reg > POS_LIM) ? rsc_pkg::DATA_MAX : q_reg[DW-1:0];
                end
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iter_reg <= iter_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
        ovf_reg  <= ovf_next;
    end

    assign done = done_reg;
    assign res  = res_reg;
    assign ovf  = ovf_reg;

endmodule

FILE: rtl/core/rsc_dpath.sv
// ----------------------------------------------------------------------------
// RPN stack calculator datapath
// Operand stack memory, stack count, arithmetic units and result register.
// ----------------------------------------------------------------------------
module rsc_dpath #(
    parameter int STACK_DEPTH = 64,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rsc_pkg::dp_cmd_t                    cmd,
    output rsc_pkg::dp_stat_t                   stat,
    input  logic signed [rsc_pkg::DATA_W-1:0]   operand_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rsc_pkg::DATA_W-1:0]   top_value,
    output logic [2:0]                          status
);

    localparam int DW    = rsc_pkg::DATA_W;
    localparam int PW    = 2 * DW;
    localparam int CNTW  = $clog2(STACK_DEPTH + 1);
    localparam int ADDRW = $clog2(STACK_DEPTH);

    localparam logic signed [PW-1:0] PMAX = PW'(rsc_pkg::DATA_MAX);
    localparam logic signed [PW-1:0] PMIN = PW'(rsc_pkg::DATA_MIN);

    logic signed [DW-1:0] stack_mem [STACK_DEPTH];
    logic signed [DW-1:0] rd_data_reg;

    logic [CNTW-1:0]      count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [DW-1:0] top_value_reg, top_value_next;
    rsc_pkg::status_t     status_reg, status_next;
    logic signed [DW-1:0] operand_reg, operand_next;
    logic signed [DW-1:0] a_reg, a_next;
    logic signed [DW-1:0] b_reg, b_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [DW-1:0] res_reg, res_next;
    logic                 ovf_reg, ovf_next;

    logic [CNTW-1:0]      cnt_m1, cnt_m2;
    logic                 wr_en, rd_en;
    logic [ADDRW-1:0]     wr_addr, rd_addr;
    logic signed [DW-1:0] wr_data;
    logic [DW:0]          add_sum, sub_diff;
    logic signed [PW-1:0] prod_sh;
    logic                 out_free;

    logic                 div_done;
    logic signed [DW-1:0] div_res;
    logic                 div_ovf;

    rsc_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.alu == rsc_pkg::ALU_DIV_START),
        .a     (a_reg),
        .b     (b_reg),
        .done  (div_done),
        .res   (div_res),
        .ovf   (div_ovf)
    );

    always_comb
    begin
        cnt_m1   = count_reg - CNTW'(1);
        cnt_m2   = count_reg - CNTW'(2);
        wr_en    = cmd.push | cmd.wr_res;
        wr_addr  = cmd.push ? count_reg[ADDRW-1:0] : cnt_m2[ADDRW-1:0];
        wr_data  = cmd.push ? operand_reg : res_reg;
        rd_en    = cmd.rd_top | cmd.rd_second;
        rd_addr  = cmd.rd_top ? cnt_m1[ADDRW-1:0] : cnt_m2[ADDRW-1:0];
        add_sum  = {a_reg[DW-1], a_reg} + {b_reg[DW-1], b_reg};
        sub_diff = {a_reg[DW-1], a_reg} - {b_reg[DW-1], b_reg};
        prod_sh  = prod_reg >>> FRAC_BITS;
        out_free = !out_valid_reg || !out_stall;

        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (cmd.wr_res)
        begin
            count_next = cnt_m1;
        end

        operand_next = cmd.capture ? operand_value : operand_reg;
        b_next       = cmd.ld_b ? rd_data_reg : b_reg;
        a_next       = cmd.ld_a ? rd_data_reg : a_reg;
        prod_next    = prod_reg;
        res_next     = res_reg;
        ovf_next     = ovf_reg;

        case (cmd.alu)
            rsc_pkg::ALU_ADD:
            begin
                ovf_next = add_sum[DW] != add_sum[DW-1];
                if (add_sum[DW] != add_sum[DW-1])
                begin
                    res_next = add_sum[DW] ? rsc_pkg::DATA_MIN : rsc_pkg::DATA_MAX;
                end
                else
                begin
                    res_next = add_sum[DW-1:0];
                end
            end
            rsc_pkg::ALU_SUB:
            begin
                ovf_next = sub_diff[DW] != sub_diff[DW-1];
                if (sub_diff[DW] != sub_diff[DW-1])
                begin
                    res_next = sub_diff[DW] ? rsc_pkg::DATA_MIN : rsc_pkg::DATA_MAX;
                end
                else
                begin
                    res_next = sub_diff[DW-1:0];
                end
            end
            rsc_pkg::ALU_MUL:
            begin
                prod_next = PW'(a_reg) * PW'(b_reg);
            end
            rsc_pkg::ALU_MUL_FIN:
            begin
                ovf_next = (prod_sh > PMAX) || (prod_sh < PMIN);
                if (prod_sh > PMAX)
                begin
                    res_next = rsc_pkg::DATA_MAX;
                end
                else if (prod_sh < PMIN)
                begin
                    res_next = rsc_pkg::DATA_MIN;
                end
                else
                begin
                    res_next = prod_sh[DW-1:0];
                end
            end
            default:
            begin
                if (div_done)
                begin
                    res_next = div_res;
                    ovf_next = div_ovf;
                end
            end
        endcase

        out_valid_next = out_valid_reg;
        top_value_next = top_value_reg;
        status_next    = status_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            status_next    = cmd.out_status;
            top_value_next = (cmd.out_status == rsc_pkg::ST_PRINTED) ? rd_data_reg : '0;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_value_reg <= top_value_next;
        status_reg    <= status_next;
        operand_reg   <= operand_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        prod_reg      <= prod_next;
        res_reg       <= res_next;
        ovf_reg       <= ovf_next;
    end

    assign stat.cnt_zero = (count_reg == '0);
    assign stat.cnt_one  = (count_reg == CNTW'(1));
    assign stat.cnt_full = (count_reg == CNTW'(STACK_DEPTH));
    assign stat.ovf      = ovf_reg;
    assign stat.div_done = div_done;
    assign stat.out_free = out_free;

    assign out_valid = out_valid_reg;
    assign top_value = top_value_reg;
    assign status    = status_reg;

endmodule

FILE: rtl/core/rsc_ctrl.sv
// ----------------------------------------------------------------------------
// RPN stack calculator controller
// Decodes each command and sequences the datapath through its steps.
// ----------------------------------------------------------------------------
module rsc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          opcode,
    output rsc_pkg::dp_cmd_t    cmd,
    input  rsc_pkg::dp_stat_t   stat
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DECODE   = 9'b000000010,
        S_LOAD_B   = 9'b000000100,
        S_LOAD_A   = 9'b000001000,
        S_EXEC     = 9'b000010000,
        S_MUL_FIN  = 9'b000100000,
        S_DIV_WAIT = 9'b001000000,
        S_WRITE    = 9'b010000000,
        S_DONE     = 9'b100000000
    } ctrl_state_t;

    ctrl_state_t       state_reg, state_next;
    rsc_pkg::opcode_t  op_reg, op_next;
    rsc_pkg::status_t  st_reg, st_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        op_next    = op_reg;
        st_next    = st_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    op_next     = rsc_pkg::opcode_t'(opcode);
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                case (op_reg)
                    rsc_pkg::OP_PUSH:
                    begin
                        if (stat.cnt_full)
                        begin
                            st_next = rsc_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                            st_next  = rsc_pkg::ST_OK;
                        end
                    end
                    rsc_pkg::OP_ADD, rsc_pkg::OP_SUB, rsc_pkg::OP_MUL, rsc_pkg::OP_DIV:
                    begin
                        if (stat.cnt_zero)
                        begin
                            st_next = rsc_pkg::ST_EMPTY;
                        end
                        else if (stat.cnt_one)
                        begin
                            cmd.clear = 1'b1;
                            st_next   = rsc_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_top = 1'b1;
                            state_next = S_LOAD_B;
                        end
                    end
                    rsc_pkg::OP_PRINT:
                    begin
                        if (stat.cnt_zero)
                        begin
                            st_next = rsc_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_top = 1'b1;
                            st_next    = rsc_pkg::ST_PRINTED;
                        end
                    end
                    rsc_pkg::OP_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                        st_next   = rsc_pkg::ST_OK;
                    end
                    default:
                    begin
                        st_next = rsc_pkg::ST_NOTIMPL;
                    end
                endcase
            end
            S_LOAD_B:
            begin
                cmd.ld_b      = 1'b1;
                cmd.rd_second = 1'b1;
                state_next    = S_LOAD_A;
            end
            S_LOAD_A:
            begin
                cmd.ld_a   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (op_reg)
                    rsc_pkg::OP_ADD:
                    begin
                        cmd.alu    = rsc_pkg::ALU_ADD;
                        state_next = S_WRITE;
                    end
                    rsc_pkg::OP_SUB:
                    begin
                        cmd.alu    = rsc_pkg::ALU_SUB;
                        state_next = S_WRITE;
                    end
                    rsc_pkg::OP_MUL:
                    begin
                        cmd.alu    = rsc_pkg::ALU_MUL;
                        state_next = S_MUL_FIN;
                    end
                    default:
                    begin
                        cmd.alu    = rsc_pkg::ALU_DIV_START;
                        state_next = S_DIV_WAIT;
                    end
                endcase
            end
            S_MUL_FIN:
            begin
                cmd.alu    = rsc_pkg::ALU_MUL_FIN;
                state_next = S_WRITE;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.wr_res = 1'b1;
                st_next    = stat.ovf ? rsc_pkg::ST_OVF : rsc_pkg::ST_OK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= rsc_pkg::OP_PUSH;
            st_reg    <= rsc_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            st_reg    <= st_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

FILE: bench/tb_rpn_stack_calculator_top.sv
// ----------------------------------------------------------------------------
// RPN stack calculator testbench
// Drives commands into the calculator in bursts and stalls the result side on
// a changing pattern. Each accepted command is run through a local model of
// the operand stack. Each result transfer is checked against the oldest
// predicted result. The directed commands cover the value extremes, every
// opcode and the underflow, overflow and divide-by-zero cases. Random
// expressions, stack fills, noise, underflow and divide-by-zero runs follow.
// ----------------------------------------------------------------------------
module tb_rpn_stack_calculator_top;

    import rsc_pkg::*;

    localparam int STACK_DEPTH    = 64;
    localparam int FRAC_BITS      = 16;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int HOLDOFF_CYCLES = 600;
    localparam int HOLDOFF_PERIOD = 4000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic signed [DATA_W-1:0] FIX_ONE = 32'sd1 <<< FRAC_BITS;

    typedef struct {
        opcode_t                  op;
        logic signed [DATA_W-1:0] val;
    } calc_cmd_t;

    typedef struct {
        logic signed [DATA_W-1:0] top;
        status_t                  st;
    } calc_result_t;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      in_valid      = 1'b0;
    logic                      in_stall;
    logic [2:0]                opcode        = OP_PUSH;
    logic signed [DATA_W-1:0]  operand_value = '0;
    logic                      out_valid;
    logic                      out_stall     = 1'b0;
    logic signed [DATA_W-1:0]  top_value;
    logic [2:0]                status;

    calc_cmd_t                 pending_cmds[$];
    calc_result_t              predicted_results[$];
    calc_cmd_t                 sent_cmd;
    calc_result_t              want;

    logic signed [DATA_W-1:0]  calc_stack [STACK_DEPTH];
    int                        calc_depth;
    int                        gen_depth;
    int                        cmd_count;
    int                        directed_count;
    int                        mismatch_count;
    int                        burst_left;
    int                        gap_left;
    int                        rx_cycle;
    int                        holdoff_left;
    int                        stall_mode;
    int                        idle_cycles;

    rpn_stack_calculator_top #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .operand_value (operand_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .top_value     (top_value),
        .status        (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [63:0] v,
                                                         inout logic ovf);
        if (v > DATA_MAX)
        begin
            ovf = 1'b1;
            return DATA_MAX;
        end
        if (v < DATA_MIN)
        begin
            ovf = 1'b1;
            return DATA_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic calc_result_t calc_apply(input calc_cmd_t cmd);
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] wide;
        logic               ovf;
        calc_result_t       res;
        res.top = '0;
        res.st  = ST_OK;
        ovf     = 1'b0;
        wide    = '0;
        case (cmd.op)
            OP_PUSH:
            begin
                if (calc_depth >= STACK_DEPTH)
                    res.st = ST_FULL;
                else
                begin
                    calc_stack[calc_depth] = cmd.val;
                    calc_depth++;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV:
            begin
                if (calc_depth < 2)
                begin
                    calc_depth = 0;
                    res.st     = ST_EMPTY;
                end
                else
                begin
                    b = calc_stack[calc_depth-1];
                    a = calc_stack[calc_depth-2];
                    case (cmd.op)
                        OP_ADD: wide = a + b;
                        OP_SUB: wide = a - b;
                        OP_MUL: wide = (a * b) >>> FRAC_BITS;
                        default:
                        begin
                            if (b == 0)
                            begin
                                ovf  = 1'b1;
                                wide = (a > 0) ? DATA_MAX : ((a < 0) ? DATA_MIN : 0);
                            end
                            else
                                wide = (a <<< FRAC_BITS) / b;
                        end
                    endcase
                    calc_stack[calc_depth-2] = clamp32(wide, ovf);
                    calc_depth--;
                    if (ovf)
                        res.st = ST_OVF;
                end
            end
            OP_PRINT:
            begin
                if (calc_depth == 0)
                    res.st = ST_EMPTY;
                else
                begin
                    res.top = calc_stack[calc_depth-1];
                    res.st  = ST_PRINTED;
                end
            end
            OP_CLEAR: calc_depth = 0;
            default:  res.st = ST_NOTIMPL;
        endcase
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 11))
            0:       return DATA_MAX;
            1:       return DATA_MIN;
            2:       return '0;
            3:       return r[31] ? -FIX_ONE : FIX_ONE;
            4, 5, 6: return {{12{r[19]}}, r[19:0]};
            7, 8:    return {{8{r[23]}}, r[23:0]};
            default: return r;
        endcase
    endfunction

    function automatic opcode_t rand_binop();
        return opcode_t'($urandom_range(OP_ADD, OP_DIV));
    endfunction

    task automatic add_cmd(input opcode_t op, input logic signed [DATA_W-1:0] val);
        calc_cmd_t cmd;
        cmd.op  = op;
        cmd.val = val;
        pending_cmds.push_back(cmd);
        cmd_count++;
        case (op)
            OP_PUSH:                        if (gen_depth < STACK_DEPTH) gen_depth++;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: gen_depth = (gen_depth < 2) ? 0 : gen_depth - 1;
            OP_CLEAR:                       gen_depth = 0;
            default:                        ;
        endcase
    endtask

    task automatic add_expression();
        int len;
        len = $urandom_range(3, 16);
        repeat (len)
        begin
            if (gen_depth < 2)
                add_cmd(OP_PUSH, rand_value());
            else if (gen_depth >= STACK_DEPTH - 1)
                add_cmd(rand_binop(), $urandom);
            else
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: add_cmd(OP_PUSH, rand_value());
                    4:          add_cmd(OP_PRINT, $urandom);
                    default:    add_cmd(rand_binop(), $urandom);
                endcase
        end
        add_cmd(OP_PRINT, $urandom);
    endtask

    task automatic add_fill();
        add_cmd(OP_CLEAR, $urandom);
        repeat (STACK_DEPTH + $urandom_range(1, 3))
            add_cmd(OP_PUSH, $urandom);
        add_cmd(OP_PRINT, $urandom);
        repeat ($urandom_range(1, 4))
            add_cmd(rand_binop(), $urandom);
        add_cmd(OP_PUSH, rand_value());
        add_cmd(OP_PRINT, $urandom);
    endtask

    initial
    begin
        calc_depth     = 0;
        gen_depth      = 0;
        cmd_count      = 0;
        mismatch_count = 0;

        add_cmd(OP_PRINT, $urandom);
        add_cmd(OP_ADD, $urandom);
        add_cmd(OP_PUSH, 5 * FIX_ONE);
        add_cmd(OP_SUB, $urandom);
        add_cmd(OP_PUSH, DATA_MAX);
        add_cmd(OP_PUSH, DATA_MAX);
        add_cmd(OP_ADD, $urandom);
        add_cmd(OP_PUSH, DATA_MIN);
        add_cmd(OP_SUB, $urandom);
        add_cmd(OP_PUSH, -32'sd1);
        add_cmd(OP_MUL, $urandom);
        add_cmd(OP_PUSH, '0);
        add_cmd(OP_DIV, $urandom);
        add_cmd(OP_PRINT, $urandom);
        add_cmd(OP_CLEAR, $urandom);
        add_cmd(OP_PUSH, FIX_ONE * 5 / 2);
        add_cmd(OP_PUSH, '0);
        add_cmd(OP_DIV, $urandom);
        add_cmd(OP_PUSH, '0);
        add_cmd(OP_PUSH, '0);
        add_cmd(OP_DIV, $urandom);
        add_cmd(OP_MUL, $urandom);
        add_cmd(OP_PUSH, DATA_MIN);
        add_cmd(OP_PUSH, 32'sd1);
        add_cmd(OP_DIV, $urandom);
        add_cmd(OP_PUSH, DATA_MIN);
        add_cmd(OP_MUL, $urandom);
        add_cmd(OP_UNKNOWN, $urandom);
        add_cmd(OP_PRINT, $urandom);
        directed_count = cmd_count;

        add_fill();
        while (cmd_count - directed_count < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 99)) inside
                [0:69]:  add_expression();
                [70:84]:
                    repeat ($urandom_range(1, 6))
                        add_cmd(opcode_t'($urandom_range(OP_PUSH, OP_UNKNOWN)), $urandom);
                [85:92]:
                begin
                    add_cmd(OP_CLEAR, $urandom);
                    if ($urandom_range(0, 1))
                        add_cmd(OP_PUSH, rand_value());
                    add_cmd(rand_binop(), $urandom);
                    add_cmd(rand_binop(), $urandom);
                    add_cmd(OP_PRINT, $urandom);
                end
                [93:96]: add_fill();
                default:
                begin
                    add_cmd(OP_PUSH, rand_value());
                    add_cmd(OP_PUSH, '0);
                    add_cmd(OP_DIV, $urandom);
                    add_cmd(OP_PRINT, $urandom);
                end
            endcase
        end

        repeat (10) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (pending_cmds.size() != 0 || in_valid || predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_rpn_stack_calculator_top: PASS");
        else
            $display("tb_rpn_stack_calculator_top: FAIL");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            opcode        <= OP_PUSH;
            operand_value <= '0;
            burst_left     = 1;
            gap_left       = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                sent_cmd = pending_cmds.pop_front();
                predicted_results.push_back(calc_apply(sent_cmd));
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    in_valid      <= 1'b1;
                    opcode        <= pending_cmds[0].op;
                    operand_value <= pending_cmds[0].val;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            rx_cycle     = 0;
            holdoff_left = 0;
            stall_mode   = 0;
        end
        else
        begin
            rx_cycle++;
            if (rx_cycle % HOLDOFF_PERIOD == 1000)
                holdoff_left = HOLDOFF_CYCLES;
            if (rx_cycle % 150 == 0)
                stall_mode = $urandom_range(0, 3);
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                out_stall <= 1'b1;
            end
            else
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= rx_cycle[2] & rx_cycle[0];
                endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_results.size() == 0)
            begin
                $display("%0t: result transfer with none expected, actual top %h status %0d",
                         $time, top_value, status);
                mismatch_count++;
            end
            else
            begin
                want = predicted_results.pop_front();
                if (top_value !== want.top)
                begin
                    $display("%0t: top_value mismatch, expected %h, actual %h",
                             $time, want.top, top_value);
                    mismatch_count++;
                end
                if (status !== want.st)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.st, status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("tb_rpn_stack_calculator_top: FAIL");
                $finish;
            end
        end
    end

endmodule
